>>> hdl/xfpr_pkg.sv
// Package for the XOR-framed packet receiver.
// Holds the payload, configuration and result-code types and reset constants.
// No dependencies.
`default_nettype none

package xfpr_pkg;

	localparam logic [7:0] HeaderReset  = 8'h00;
	localparam logic [7:0] MinLenReset  = 8'd4;
	localparam logic [7:0] TimeoutReset = 8'd20;
	localparam logic [7:0] QueryReset   = 8'h11;

	typedef enum logic [1:0] {
		REG_HEADER  = 2'd0,
		REG_MIN_LEN = 2'd1,
		REG_TIMEOUT = 2'd2,
		REG_QUERY   = 2'd3
	} reg_index_t;

	typedef enum logic [2:0] {
		RC_REQUEST    = 3'd0,
		RC_QUERY      = 3'd1,
		RC_REPEAT     = 3'd2,
		RC_BAD_HEADER = 3'd3,
		RC_BAD_LENGTH = 3'd4,
		RC_TIMEOUT    = 3'd5,
		RC_CHECKSUM   = 3'd6
	} result_code_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_LEN  = 3'b010,
		PH_BODY = 3'b100
	} phase_t;

	typedef struct packed {
		logic       operation;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0] result_code;
		logic [7:0] sequence_res;
		logic [7:0] message_type;
		logic [7:0] frame_length;
	} out_item_t;

	typedef struct packed {
		logic [7:0] header_byte;
		logic [7:0] min_length;
		logic [7:0] timeout_ticks;
		logic [7:0] query_type;
	} cfg_regs_t;

endpackage

`default_nettype wire

>>> hdl/xor_framed_packet_receiver.sv
// XOR-framed packet receiver, top level.
// Path: the input item is registered in item_s1 and decoded there; its result is registered in out_data_q.
// Throughput: one item per cycle while in_stall is low; an item with no result passes even while out is stalled.
// The frame state update of one item is the loop that sets the rate.
// Reset: arst_n clears frame state, pipeline valids and loads config reset values.
// Depends on xfpr_pkg, xfpr_cfg_regs, xfpr_frame_fsm.
`default_nettype none

module xor_framed_packet_receiver import xfpr_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire in_item_t   in_data,
	output logic            out_valid,
	input  wire logic       out_stall,
	output out_item_t       out_data,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data
);

	cfg_regs_t cfg;
	logic      valid_s1;
	in_item_t  item_s1;
	logic      has_result;
	out_item_t result;
	logic      advance;
	logic      fire;
	logic      out_valid_q;
	out_item_t out_data_q;

	assign cfg_ready = 1'b1;

	xfpr_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	xfpr_frame_fsm u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (valid_s1),
		.item       (item_s1),
		.fire       (fire),
		.has_result (has_result),
		.result     (result)
	);

	assign advance  = !has_result || !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid)
			item_s1 <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (!(out_valid_q && out_stall))
			out_valid_q <= fire && has_result;
	end

	always_ff @(posedge clk) begin
		if (fire && has_result)
			out_data_q <= result;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

>>> hdl/xfpr_cfg_regs.sv
// Configuration register file of the receiver.
// Depends on xfpr_pkg.
`default_nettype none

module xfpr_cfg_regs import xfpr_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       wr_en,
	input  wire logic [1:0] wr_index,
	input  wire logic [7:0] wr_data,
	output cfg_regs_t       cfg
);

	cfg_regs_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_byte   <= HeaderReset;
			cfg_q.min_length    <= MinLenReset;
			cfg_q.timeout_ticks <= TimeoutReset;
			cfg_q.query_type    <= QueryReset;
		end else if (wr_en) begin
			unique case (reg_index_t'(wr_index))
				REG_HEADER:  cfg_q.header_byte   <= wr_data;
				REG_MIN_LEN: cfg_q.min_length    <= wr_data;
				REG_TIMEOUT: cfg_q.timeout_ticks <= wr_data;
				REG_QUERY:   cfg_q.query_type    <= wr_data;
				default:     cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> hdl/xfpr_frame_fsm.sv
// Frame tracking state and per-item decode: header, length, body, check byte, timeout.
// Depends on xfpr_pkg.
`default_nettype none

module xfpr_frame_fsm import xfpr_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cfg_regs_t cfg,
	input  wire logic      item_valid,
	input  wire in_item_t  item,
	input  wire logic      fire,
	output logic           has_result,
	output out_item_t      result
);

	phase_t     phase_q, phase_d;
	logic [7:0] count_q, count_d;
	logic [7:0] exp_len_q, exp_len_d;
	logic [7:0] xor_q, xor_d;
	logic [7:0] seq_q, seq_d;
	logic [7:0] type_q, type_d;
	logic [7:0] last_seq_q, last_seq_d;
	logic [7:0] ticks_q, ticks_d;

	always_comb begin
		logic [7:0] b;
		logic [7:0] tl;
		b          = item.data_byte;
		tl         = 8'd0;
		phase_d    = phase_q;
		count_d    = count_q;
		exp_len_d  = exp_len_q;
		xor_d      = xor_q;
		seq_d      = seq_q;
		type_d     = type_q;
		last_seq_d = last_seq_q;
		ticks_d    = ticks_q;
		has_result = 1'b0;
		result     = '0;

		if (item.operation) begin
			if (phase_q == PH_BODY) begin
				tl = (ticks_q != 8'd0) ? ticks_q - 8'd1 : 8'd0;
				ticks_d = tl;
				if (tl == 8'd0) begin
					phase_d    = PH_IDLE;
					count_d    = 8'd0;
					has_result = 1'b1;
					result     = '{RC_TIMEOUT, seq_q, type_q, exp_len_q};
				end
			end
		end else begin
			unique case (phase_q)
				PH_LEN: begin
					if (b < cfg.min_length) begin
						phase_d    = PH_IDLE;
						count_d    = 8'd0;
						ticks_d    = 8'd0;
						has_result = 1'b1;
						result     = '{RC_BAD_LENGTH, 8'd0, 8'd0, b};
					end else begin
						exp_len_d = b;
						seq_d     = 8'd0;
						type_d    = 8'd0;
						if (b == 8'd0)
							xor_d = 8'd0;
						else if (b == 8'd1)
							xor_d = cfg.header_byte;
						else
							xor_d = cfg.header_byte ^ b;
						if (cfg.timeout_ticks == 8'd0) begin
							phase_d    = PH_IDLE;
							count_d    = 8'd0;
							ticks_d    = 8'd0;
							has_result = 1'b1;
							result     = '{RC_TIMEOUT, 8'd0, 8'd0, b};
						end else begin
							phase_d = PH_BODY;
							count_d = 8'd2;
							ticks_d = cfg.timeout_ticks;
						end
					end
				end
				PH_BODY: begin
					if (count_q == 8'd2)
						seq_d = b;
					if (count_q == 8'd3)
						type_d = b;
					if (count_q < exp_len_q) begin
						xor_d   = xor_q ^ b;
						count_d = count_q + 8'd1;
					end else begin
						phase_d    = PH_IDLE;
						count_d    = 8'd0;
						ticks_d    = 8'd0;
						has_result = 1'b1;
						if (b != xor_q)
							result = '{RC_CHECKSUM, seq_d, type_d, exp_len_q};
						else if (last_seq_q != 8'd0 && last_seq_q == seq_d)
							result = '{RC_REPEAT, seq_d, type_d, exp_len_q};
						else begin
							last_seq_d = seq_d;
							if (type_d == cfg.query_type)
								result = '{RC_QUERY, seq_d, type_d, exp_len_q};
							else
								result = '{RC_REQUEST, seq_d, type_d, exp_len_q};
						end
					end
				end
				default: begin
					if (b != cfg.header_byte) begin
						phase_d    = PH_IDLE;
						count_d    = 8'd0;
						ticks_d    = 8'd0;
						has_result = 1'b1;
						result     = '{RC_BAD_HEADER, 8'd0, 8'd0, 8'd0};
					end else begin
						phase_d = PH_LEN;
						count_d = 8'd1;
					end
				end
			endcase
		end

		if (!item_valid)
			has_result = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			count_q    <= 8'd0;
			exp_len_q  <= 8'd0;
			xor_q      <= 8'd0;
			seq_q      <= 8'd0;
			type_q     <= 8'd0;
			last_seq_q <= 8'd0;
			ticks_q    <= 8'd0;
		end else if (fire) begin
			phase_q    <= phase_d;
			count_q    <= count_d;
			exp_len_q  <= exp_len_d;
			xor_q      <= xor_d;
			seq_q      <= seq_d;
			type_q     <= type_d;
			last_seq_q <= last_seq_d;
			ticks_q    <= ticks_d;
		end
	end

endmodule

`default_nettype wire

>>> bench/xor_framed_packet_receiver_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for xor_framed_packet_receiver: directed frames, then random framed traffic
// with ticks, noise, config sweeps and random stalls, checked against a frame tracker.
// Depends on xfpr_pkg and the receiver RTL.

module xor_framed_packet_receiver_tb;
	import xfpr_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 600_000;
	localparam int          BYTE_TARGET = 1150;

	typedef enum logic [1:0] {
		ROW_BYTE,
		ROW_TICK,
		ROW_REG
	} row_kind_t;

	typedef struct packed {
		row_kind_t  kind;
		reg_index_t index;
		logic [7:0] value;
		logic       typed;
		logic       has_res;
		out_item_t  res;
	} script_row_t;

	localparam out_item_t NO_RES = '0;
	localparam int DIRECTED_ROWS = 30;

	// typed rows carry their own outcome, the rest go through the tracker
	localparam script_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{ROW_TICK, REG_HEADER,  8'h00, 1'b1, 1'b0, NO_RES},
		'{ROW_BYTE, REG_HEADER,  8'hFF, 1'b1, 1'b1, '{RC_BAD_HEADER, 8'h00, 8'h00, 8'h00}},
		'{ROW_BYTE, REG_HEADER,  8'h00, 1'b1, 1'b0, NO_RES},
		'{ROW_BYTE, REG_HEADER,  8'h03, 1'b1, 1'b1, '{RC_BAD_LENGTH, 8'h00, 8'h00, 8'h03}},
		'{ROW_BYTE, REG_HEADER,  8'h00, 1'b0, 1'b0, NO_RES},
		'{ROW_BYTE, REG_HEADER,  8'h04, 1'b0, 1'b0, NO_RES},
		'{ROW_BYTE, REG_HEADER,  8'h01, 1'b0, 1'b0, NO_RES},
		'{ROW_BYTE, REG_HEADER,  8'h11, 1'b0, 1'b0, NO_RES},
		'{ROW_BYTE, REG_HEADER,  8'h14, 1'b0, 1'b0, NO_RES},
		'{ROW_BYTE, REG_HEADER,  8'h00, 1'b0, 1'b0, NO_RES},
		'{ROW_BYTE, REG_HEADER,  8'h04, 1'b0, 1'b0, NO_RES},
		'{ROW_BYTE, REG_HEADER,  8'h01, 1'b0, 1'b0, NO_RES},
		'{ROW_BYTE, REG_HEADER,  8'hFF, 1'b0, 1'b0, NO_RES},
		'{ROW_BYTE, REG_HEADER,  8'hFA, 1'b0, 1'b0, NO_RES},
		'{ROW_REG,  REG_TIMEOUT, 8'h01, 1'b0, 1'b0, NO_RES},
		'{ROW_BYTE, REG_HEADER,  8'h00, 1'b0, 1'b0, NO_RES},
		'{ROW_BYTE, REG_HEADER,  8'h04, 1'b0, 1'b0, NO_RES},
		'{ROW_TICK, REG_HEADER,  8'hFF, 1'b1, 1'b1, '{RC_TIMEOUT, 8'h00, 8'h00, 8'h04}},
		'{ROW_REG,  REG_TIMEOUT, 8'h00, 1'b0, 1'b0, NO_RES},
		'{ROW_BYTE, REG_HEADER,  8'h00, 1'b0, 1'b0, NO_RES},
		'{ROW_BYTE, REG_HEADER,  8'hFF, 1'b1, 1'b1, '{RC_TIMEOUT, 8'h00, 8'h00, 8'hFF}},
		'{ROW_REG,  REG_MIN_LEN, 8'h00, 1'b0, 1'b0, NO_RES},
		'{ROW_REG,  REG_TIMEOUT, 8'hFF, 1'b0, 1'b0, NO_RES},
		'{ROW_REG,  REG_HEADER,  8'hFF, 1'b0, 1'b0, NO_RES},
		'{ROW_BYTE, REG_HEADER,  8'hFF, 1'b0, 1'b0, NO_RES},
		'{ROW_BYTE, REG_HEADER,  8'h00, 1'b0, 1'b0, NO_RES},
		'{ROW_BYTE, REG_HEADER,  8'h00, 1'b0, 1'b0, NO_RES},
		'{ROW_BYTE, REG_HEADER,  8'hFF, 1'b0, 1'b0, NO_RES},
		'{ROW_BYTE, REG_HEADER,  8'h01, 1'b0, 1'b0, NO_RES},
		'{ROW_BYTE, REG_HEADER,  8'hFF, 1'b0, 1'b0, NO_RES}
	};

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	in_item_t   in_data   = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	out_item_t  out_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_data  = '0;

	// frame tracker state
	cfg_regs_t  regs        = '{HeaderReset, MinLenReset, TimeoutReset, QueryReset};
	phase_t     rx_phase    = PH_IDLE;
	logic [7:0] rx_count    = '0;
	logic [7:0] rx_len      = '0;
	logic [7:0] rx_xor      = '0;
	logic [7:0] rx_seq      = '0;
	logic [7:0] rx_type     = '0;
	logic [7:0] rx_last_seq = '0;
	logic [7:0] rx_ticks    = '0;

	out_item_t  pending_outcomes[$];
	out_item_t  oldest_outcome;
	int         mismatches   = 0;
	int         bytes_sent   = 0;
	int         send_mode    = 0;
	int         recv_mode    = 0;
	int         hold_request = 0;

	xor_framed_packet_receiver i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic out_item_t make_result(input result_code_t code, input logic [7:0] seq,
			input logic [7:0] msg_type, input logic [7:0] len);
		out_item_t r;
		r.result_code  = code;
		r.sequence_res = seq;
		r.message_type = msg_type;
		r.frame_length = len;
		return r;
	endfunction

	function automatic void drop_to_idle();
		rx_phase = PH_IDLE;
		rx_count = '0;
		rx_ticks = '0;
	endfunction

	function automatic bit track_frame(input in_item_t it, output out_item_t res);
		logic [7:0] b;
		b   = it.data_byte;
		res = '0;
		if (it.operation) begin
			if (rx_phase != PH_BODY)
				return 1'b0;
			if (rx_ticks != 0)
				rx_ticks--;
			if (rx_ticks != 0)
				return 1'b0;
			drop_to_idle();
			res = make_result(RC_TIMEOUT, rx_seq, rx_type, rx_len);
			return 1'b1;
		end
		case (rx_phase)
			PH_LEN: begin
				if (b < regs.min_length) begin
					drop_to_idle();
					res = make_result(RC_BAD_LENGTH, 8'h00, 8'h00, b);
					return 1'b1;
				end
				rx_len  = b;
				rx_seq  = '0;
				rx_type = '0;
				if (b == 8'd0)
					rx_xor = '0;
				else if (b == 8'd1)
					rx_xor = regs.header_byte;
				else
					rx_xor = regs.header_byte ^ b;
				rx_count = 8'd2;
				if (regs.timeout_ticks == 0) begin
					drop_to_idle();
					res = make_result(RC_TIMEOUT, 8'h00, 8'h00, b);
					return 1'b1;
				end
				rx_ticks = regs.timeout_ticks;
				rx_phase = PH_BODY;
				return 1'b0;
			end
			PH_BODY: begin
				if (rx_count == 8'd2)
					rx_seq = b;
				if (rx_count == 8'd3)
					rx_type = b;
				if (rx_count < rx_len) begin
					rx_xor ^= b;
					rx_count++;
					return 1'b0;
				end
				drop_to_idle();
				if (b != rx_xor)
					res = make_result(RC_CHECKSUM, rx_seq, rx_type, rx_len);
				else if (rx_last_seq != 0 && rx_last_seq == rx_seq)
					res = make_result(RC_REPEAT, rx_seq, rx_type, rx_len);
				else begin
					rx_last_seq = rx_seq;
					if (rx_type == regs.query_type)
						res = make_result(RC_QUERY, rx_seq, rx_type, rx_len);
					else
						res = make_result(RC_REQUEST, rx_seq, rx_type, rx_len);
				end
				return 1'b1;
			end
			default: begin
				if (b != regs.header_byte) begin
					drop_to_idle();
					res = make_result(RC_BAD_HEADER, 8'h00, 8'h00, 8'h00);
					return 1'b1;
				end
				rx_phase = PH_LEN;
				rx_count = 8'd1;
				return 1'b0;
			end
		endcase
	endfunction

	function automatic int draw_wait(input int mode);
		case (mode)
			0: return 0;
			1: return $urandom_range(0, 16);
			default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
		endcase
	endfunction

	task automatic flag_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: mismatch: %s", $time, msg);
	endtask

	task automatic send_item(input in_item_t it, output bit got, output out_item_t res);
		int n;
		n = draw_wait(send_mode);
		if (n != 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
		got = track_frame(it, res);
	endtask

	task automatic offer(input logic op, input logic [7:0] b);
		in_item_t  it;
		out_item_t res;
		bit        got;
		it.operation = op;
		it.data_byte = b;
		send_item(it, got, res);
		if (got)
			pending_outcomes.push_back(res);
		if (!op)
			bytes_sent++;
	endtask

	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// leaves cfg_valid high so back-to-back writes stay one transfer per edge
	task automatic write_reg(input reg_index_t idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_HEADER:  regs.header_byte   = val;
			REG_MIN_LEN: regs.min_length    = val;
			REG_TIMEOUT: regs.timeout_ticks = val;
			default:     regs.query_type    = val;
		endcase
	endtask

	task automatic send_frame();
		logic [7:0] fb[$];
		logic [7:0] x;
		int         len, last_pos, stop_at, pick;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			len = regs.min_length + $urandom_range(0, 6);
		else if (pick < 82)
			len = $urandom_range(0, 3);
		else if (pick < 92)
			len = (regs.min_length == 0) ? 0 : $urandom_range(0, regs.min_length - 1);
		else if (pick < 98)
			len = $urandom_range(4, 40);
		else
			len = 255;
		if (len > 255)
			len = 255;
		fb.push_back(regs.header_byte);
		fb.push_back(8'(len));
		last_pos = (len < 2) ? 2 : len;
		for (int k = 2; k < last_pos; k++) begin
			if (k == 2)
				fb.push_back(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3))
					: 8'($urandom));
			else if (k == 3)
				fb.push_back(($urandom_range(0, 2) == 0) ? regs.query_type : 8'($urandom));
			else
				fb.push_back(8'($urandom));
		end
		x = '0;
		for (int k = 0; k < len; k++)
			x ^= fb[k];
		if ($urandom_range(0, 9) == 0)
			x ^= 8'(1 << $urandom_range(0, 7));
		fb.push_back(x);
		stop_at = ($urandom_range(0, 19) == 0) ? $urandom_range(1, fb.size() - 1) : fb.size();
		for (int k = 0; k < stop_at; k++) begin
			if (k >= 2 && $urandom_range(0, 15) == 0)
				offer(1'b1, 8'($urandom));
			offer(1'b0, fb[k]);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_outcomes.size() == 0)
				flag_mismatch($sformatf("unexpected result code %0d seq %02h type %02h len %02h",
					out_data.result_code, out_data.sequence_res, out_data.message_type,
					out_data.frame_length));
			else begin
				oldest_outcome = pending_outcomes.pop_front();
				if (out_data.result_code !== oldest_outcome.result_code
						|| out_data.sequence_res !== oldest_outcome.sequence_res
						|| out_data.message_type !== oldest_outcome.message_type
						|| out_data.frame_length !== oldest_outcome.frame_length)
					flag_mismatch($sformatf({"want code %0d seq %02h type %02h len %02h, ",
						"got code %0d seq %02h type %02h len %02h"},
						oldest_outcome.result_code, oldest_outcome.sequence_res,
						oldest_outcome.message_type, oldest_outcome.frame_length,
						out_data.result_code, out_data.sequence_res,
						out_data.message_type, out_data.frame_length));
			end
		end
	end

	initial begin : receiver
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_request != 0) begin
				n = hold_request;
				hold_request = 0;
			end else
				n = draw_wait(recv_mode);
			if (n != 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : stimulus
		script_row_t row;
		in_item_t    it;
		out_item_t   res;
		bit          got;
		logic [7:0]  b;
		int          phase_no, phase_end;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_mode = 1;
		recv_mode = 2;

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			row = DIRECTED[i];
			if (row.kind == ROW_REG) begin
				if (i == 0 || DIRECTED[i - 1].kind != ROW_REG)
					wait_quiet();
				write_reg(row.index, row.value);
				if (i == DIRECTED_ROWS - 1 || DIRECTED[i + 1].kind != ROW_REG)
					cfg_valid <= 1'b0;
			end else begin
				it.operation = (row.kind == ROW_TICK);
				it.data_byte = row.value;
				send_item(it, got, res);
				if (row.typed) begin
					if (row.has_res)
						pending_outcomes.push_back(row.res);
				end else if (got)
					pending_outcomes.push_back(res);
			end
		end

		phase_no = 0;
		while (bytes_sent < BYTE_TARGET) begin
			wait_quiet();
			case ($urandom_range(0, 2))
				0: b = 8'h00;
				1: b = 8'hFF;
				default: b = 8'($urandom);
			endcase
			write_reg(REG_HEADER, b);
			if (phase_no == 4)
				b = 8'hFF;
			else case ($urandom_range(0, 3))
				0: b = 8'd0;
				1: b = 8'd1;
				2: b = MinLenReset;
				default: b = 8'($urandom_range(0, 8));
			endcase
			write_reg(REG_MIN_LEN, b);
			case ($urandom_range(0, 4))
				0: b = 8'd1;
				1: b = 8'd2;
				2: b = TimeoutReset;
				3: b = 8'hFF;
				default: b = 8'($urandom_range(0, 40));
			endcase
			write_reg(REG_TIMEOUT, b);
			case ($urandom_range(0, 3))
				0: b = 8'h00;
				1: b = QueryReset;
				2: b = 8'hFF;
				default: b = 8'($urandom);
			endcase
			write_reg(REG_QUERY, b);
			cfg_valid <= 1'b0;
			send_mode = $urandom_range(0, 2);
			recv_mode = $urandom_range(0, 2);

			if (phase_no == 1) begin
				// output held off while bad-header bytes keep coming, so the input backs up
				send_mode = 0;
				hold_request = 300;
				repeat (80) begin
					b = 8'($urandom);
					if (b == regs.header_byte)
						b = ~b;
					offer(1'b0, b);
				end
			end

			phase_end = bytes_sent + 110;
			while (bytes_sent < phase_end) begin
				if ($urandom_range(0, 9) == 0)
					repeat ($urandom_range(1, 3))
						offer(1'($urandom_range(0, 1)), 8'($urandom));
				send_frame();
			end
			phase_no++;
		end

		wait_quiet();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> files.f
hdl/xfpr_pkg.sv
hdl/xfpr_cfg_regs.sv
hdl/xfpr_frame_fsm.sv
hdl/xor_framed_packet_receiver.sv
bench/xor_framed_packet_receiver_tb.sv
